// File: rtl/sorted_insert_priority_queue_core_assert.svh
// Assertion macros shared by the queue modules.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Check a property while out of reset.
`define SIPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SIPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/sipq_pkg.sv
package sipq_pkg;

  localparam int DEPTH = 8;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int CNT_W = (CNT_BITS > 4) ? CNT_BITS : 4;
  localparam int ID_W = 16;
  localparam int PRI_W = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic    load;
    logic    insert;
    logic    remove;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// File: rtl/sipq_ctrl.sv
`include "sorted_insert_priority_queue_core_assert.svh"

module sipq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sipq_pkg::dp_stat_t stat_i,
  output sipq_pkg::dp_cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == S_HOLD);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.insert = 1'b0;
    cmd_o.remove = 1'b0;
    cmd_o.status = sipq_pkg::STATUS_OK;
    if (op_i == sipq_pkg::OP_INSERT) begin
      if (stat_i.full) begin
        cmd_o.status = sipq_pkg::STATUS_OVERFLOW;
      end else begin
        cmd_o.insert = accept;
      end
    end else begin
      if (stat_i.empty) begin
        cmd_o.status = sipq_pkg::STATUS_UNDERFLOW;
      end else begin
        cmd_o.remove = accept;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = S_HOLD;
    end else if (out_ready_i) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SIPQ_ASSERT(a_ins_not_full, cmd_o.insert |-> !stat_i.full, "insert issued while full")
  `SIPQ_ASSERT(a_rem_not_empty, cmd_o.remove |-> !stat_i.empty, "remove issued while empty")
  `SIPQ_ASSERT(a_load_shows, cmd_o.load |=> out_valid_o, "accepted beat produced no result")
  `SIPQ_ASSERT_ALWAYS(a_one_op, !(cmd_o.insert && cmd_o.remove), "insert and remove together")

endmodule

// File: rtl/sipq_datapath.sv
`include "sorted_insert_priority_queue_core_assert.svh"

module sipq_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sipq_pkg::dp_cmd_t            cmd_i,
  output sipq_pkg::dp_stat_t           stat_o,
  input  logic [sipq_pkg::ID_W-1:0]    job_id_i,
  input  logic [sipq_pkg::PRI_W-1:0]   job_priority_i,
  output logic [1:0]                   status_o,
  output logic [sipq_pkg::ID_W-1:0]    removed_id_o,
  output logic [sipq_pkg::PRI_W-1:0]   removed_priority_o,
  output logic [3:0]                   occupancy_o
);

  logic [sipq_pkg::ID_W-1:0]  id_q  [sipq_pkg::DEPTH];
  logic [sipq_pkg::PRI_W-1:0] pri_q [sipq_pkg::DEPTH];
  logic [sipq_pkg::CNT_W-1:0] count_q, count_d;
  logic [sipq_pkg::DEPTH-1:0] gt;

  sipq_pkg::status_e          status_q;
  logic [sipq_pkg::ID_W-1:0]  rid_q;
  logic [sipq_pkg::PRI_W-1:0] rpri_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == sipq_pkg::CNT_W'(sipq_pkg::DEPTH));

  // Slots that move back on insert: live and of larger priority value.
  always_comb begin
    for (int i = 0; i < sipq_pkg::DEPTH; i++) begin
      gt[i] = (sipq_pkg::CNT_W'(i) < count_q) && (pri_q[i] > job_priority_i);
    end
  end

  for (genvar g = 0; g < sipq_pkg::DEPTH; g++) begin : g_slot
    logic [sipq_pkg::ID_W-1:0]  ins_id, rem_id;
    logic [sipq_pkg::PRI_W-1:0] ins_pri, rem_pri;
    logic                       ins_wr;

    assign ins_wr = gt[g] || (count_q == sipq_pkg::CNT_W'(g));

    if (g == 0) begin : g_front
      assign ins_id  = job_id_i;
      assign ins_pri = job_priority_i;
    end else begin : g_back
      assign ins_id  = gt[g-1] ? id_q[g-1]  : job_id_i;
      assign ins_pri = gt[g-1] ? pri_q[g-1] : job_priority_i;
    end

    if (g == sipq_pkg::DEPTH - 1) begin : g_last
      assign rem_id  = id_q[g];
      assign rem_pri = pri_q[g];
    end else begin : g_mid
      assign rem_id  = id_q[g+1];
      assign rem_pri = pri_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && ins_wr) begin
        id_q[g]  <= ins_id;
        pri_q[g] <= ins_pri;
      end else if (cmd_i.remove) begin
        id_q[g]  <= rem_id;
        pri_q[g] <= rem_pri;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.remove) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result beat: drop zeros on the removed fields unless a job left.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= cmd_i.status;
      rid_q    <= cmd_i.remove ? id_q[0]  : '0;
      rpri_q   <= cmd_i.remove ? pri_q[0] : '0;
    end
  end

  assign status_o           = status_q;
  assign removed_id_o       = rid_q;
  assign removed_priority_o = rpri_q;
  assign occupancy_o        = count_q[3:0];

  `SIPQ_ASSERT(a_count_range, count_q <= sipq_pkg::CNT_W'(sipq_pkg::DEPTH), "count past depth")
  `SIPQ_ASSERT(a_ins_count, cmd_i.insert |=> count_q == $past(count_q) + 1'b1, "insert count slip")
  `SIPQ_ASSERT(a_sorted_front, count_q >= sipq_pkg::CNT_W'(2) |-> pri_q[0] <= pri_q[1], "front out of order")

endmodule

// File: rtl/sorted_insert_priority_queue_core.sv
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   op_i, job_id_i, job_priority_i
// out      out_valid_o / out_ready_i status_o, removed_id_o, removed_priority_o, occupancy_o
//
// Every slot compares against the new priority in parallel and shifts on the accepting edge,
// so one insert or remove is accepted per cycle while a held result does not block input.
// The result is registered and shows the cycle after acceptance.
// A held result blocks input only while out_ready_i stays low.
// Reset clears the job count; slot contents are left as they are.
module sorted_insert_priority_queue_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [sipq_pkg::ID_W-1:0]   job_id_i,
  input  logic [sipq_pkg::PRI_W-1:0]  job_priority_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [sipq_pkg::ID_W-1:0]   removed_id_o,
  output logic [sipq_pkg::PRI_W-1:0]  removed_priority_o,
  output logic [3:0]                  occupancy_o
);

  sipq_pkg::dp_cmd_t  cmd;
  sipq_pkg::dp_stat_t stat;

  sipq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sipq_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .job_id_i           (job_id_i),
    .job_priority_i     (job_priority_i),
    .status_o           (status_o),
    .removed_id_o       (removed_id_o),
    .removed_priority_o (removed_priority_o),
    .occupancy_o        (occupancy_o)
  );

endmodule

// File: bench/sorted_insert_priority_queue_core_test.sv
module sorted_insert_priority_queue_core_test;

  typedef struct {
    sipq_pkg::op_e              op;
    logic [sipq_pkg::ID_W-1:0]  id;
    logic [sipq_pkg::PRI_W-1:0] pri;
  } job_req_t;

  typedef struct {
    sipq_pkg::status_e          status;
    logic [sipq_pkg::ID_W-1:0]  rid;
    logic [sipq_pkg::PRI_W-1:0] rpri;
    logic [3:0]                 occ;
  } job_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       op_i = 1'b0;
  logic [sipq_pkg::ID_W-1:0]  job_id_i = '0;
  logic [sipq_pkg::PRI_W-1:0] job_priority_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [1:0]                 status_o;
  logic [sipq_pkg::ID_W-1:0]  removed_id_o;
  logic [sipq_pkg::PRI_W-1:0] removed_priority_o;
  logic [3:0]                 occupancy_o;

  sorted_insert_priority_queue_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .job_id_i           (job_id_i),
    .job_priority_i     (job_priority_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .removed_id_o       (removed_id_o),
    .removed_priority_o (removed_priority_o),
    .occupancy_o        (occupancy_o)
  );

  job_req_t                   pending_jobs[$];
  job_result_t                expected_results[$];
  job_req_t                   cur_req;
  logic [sipq_pkg::ID_W-1:0]  sched_id[sipq_pkg::DEPTH];
  logic [sipq_pkg::PRI_W-1:0] sched_pri[sipq_pkg::DEPTH];
  int                         sched_count = 0;
  int                         fail_count = 0;
  int                         gap_left = 0;
  int                         burst_left = 1;
  int                         rx_cycle = 0;
  int                         rx_hold_left = 0;
  int                         rx_mode = 0;
  int                         rx_mode_left = 0;
  logic                       rx_next_ready;

  function automatic job_result_t apply_job(job_req_t req);
    job_result_t res;
    int pos;
    res.status = sipq_pkg::STATUS_OK;
    res.rid = '0;
    res.rpri = '0;
    if (req.op == sipq_pkg::OP_INSERT) begin
      if (sched_count >= sipq_pkg::DEPTH) begin
        res.status = sipq_pkg::STATUS_OVERFLOW;
      end else begin
        pos = sched_count;
        while (pos > 0 && sched_pri[pos-1] > req.pri) begin
          sched_id[pos] = sched_id[pos-1];
          sched_pri[pos] = sched_pri[pos-1];
          pos--;
        end
        sched_id[pos] = req.id;
        sched_pri[pos] = req.pri;
        sched_count++;
      end
    end else begin
      if (sched_count == 0) begin
        res.status = sipq_pkg::STATUS_UNDERFLOW;
      end else begin
        res.rid = sched_id[0];
        res.rpri = sched_pri[0];
        for (pos = 1; pos < sched_count; pos++) begin
          sched_id[pos-1] = sched_id[pos];
          sched_pri[pos-1] = sched_pri[pos];
        end
        sched_count--;
      end
    end
    res.occ = 4'(sched_count);
    return res;
  endfunction

  task automatic add_job(sipq_pkg::op_e op, logic [sipq_pkg::ID_W-1:0] id,
                         logic [sipq_pkg::PRI_W-1:0] pri);
    job_req_t req;
    req.op = op;
    req.id = id;
    req.pri = pri;
    pending_jobs.push_back(req);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(apply_job(cur_req));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_jobs.size() > 0) begin
          cur_req = pending_jobs.pop_front();
          in_valid_i <= 1'b1;
          op_i <= cur_req.op;
          job_id_i <= cur_req.id;
          job_priority_i <= cur_req.pri;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // periodic long hold-off lets the output back up and stall input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rx_next_ready = 1'b0;
      end else if (rx_cycle % 600 == 300) begin
        rx_hold_left = 50;
        rx_next_ready = 1'b0;
      end else begin
        if (rx_mode_left <= 0) begin
          rx_mode = $urandom_range(2);
          rx_mode_left = $urandom_range(5, 60);
        end
        rx_mode_left--;
        case (rx_mode)
          0: rx_next_ready = 1'b1;
          1: rx_next_ready = 1'($urandom_range(1));
          default: rx_next_ready = ($urandom_range(3) == 0);
        endcase
      end
      out_ready_i <= rx_next_ready;
    end
  end

  always @(posedge clk_i) begin
    job_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result beat: status %0d id %h priority %h occupancy %0d",
                   status_o, removed_id_o, removed_priority_o, occupancy_o);
        end
      end else begin
        exp_res = expected_results.pop_front();
        if (status_o !== exp_res.status || removed_id_o !== exp_res.rid ||
            removed_priority_o !== exp_res.rpri || occupancy_o !== exp_res.occ) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result mismatch: status %0d/%0d id %h/%h priority %h/%h occupancy %0d/%0d",
                     exp_res.status, status_o, exp_res.rid, removed_id_o,
                     exp_res.rpri, removed_priority_o, exp_res.occ, occupancy_o);
          end
        end
      end
    end
  end

  initial begin
    int added;
    int seg_len;
    int ins_pct;
    int pri_span;
    int k;

    add_job(sipq_pkg::OP_REMOVE, 16'hffff, 8'hff);
    add_job(sipq_pkg::OP_INSERT, 16'hffff, 8'hff);
    add_job(sipq_pkg::OP_INSERT, 16'h0000, 8'h00);
    add_job(sipq_pkg::OP_INSERT, 16'h0007, 8'h07);
    add_job(sipq_pkg::OP_INSERT, 16'h0107, 8'h07);
    add_job(sipq_pkg::OP_INSERT, 16'h0207, 8'h07);
    add_job(sipq_pkg::OP_INSERT, 16'h8000, 8'h80);
    add_job(sipq_pkg::OP_INSERT, 16'h5555, 8'h01);
    add_job(sipq_pkg::OP_INSERT, 16'haaaa, 8'hfe);
    add_job(sipq_pkg::OP_INSERT, 16'h1234, 8'h00);
    for (k = 0; k < sipq_pkg::DEPTH; k++) begin
      add_job(sipq_pkg::OP_REMOVE, 16'($urandom), 8'($urandom));
    end
    add_job(sipq_pkg::OP_REMOVE, 16'h0000, 8'h00);

    added = 0;
    while (added < 1700) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(3))
        0: ins_pct = 15;
        1: ins_pct = 50;
        2: ins_pct = 85;
        default: ins_pct = $urandom_range(100);
      endcase
      case ($urandom_range(2))
        0: pri_span = 255;
        1: pri_span = 3;
        default: pri_span = 15;
      endcase
      for (k = 0; k < seg_len; k++) begin
        add_job(($urandom_range(99) < ins_pct) ? sipq_pkg::OP_INSERT : sipq_pkg::OP_REMOVE,
                16'($urandom_range(16'hffff)), 8'($urandom_range(pri_span)));
      end
      added += seg_len;
    end

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_jobs.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    fail_count += expected_results.size();

    if (fail_count == 0) begin
      $display("sorted_insert_priority_queue_core verification clean");
    end else begin
      $display("sorted_insert_priority_queue_core verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("sorted_insert_priority_queue_core verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/sipq_pkg.sv
rtl/sipq_ctrl.sv
rtl/sipq_datapath.sv
rtl/sorted_insert_priority_queue_core.sv
bench/sorted_insert_priority_queue_core_test.sv
